/* rtl/core/olist_pkg.sv */
package olist_pkg;

    localparam int DEPTH = 16;
    localparam int VAL_W = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // controls broadcast to every cell of the chain
    typedef struct packed {
        logic ins;      // insert accepted: shift back one place
        logic start;    // any word accepted: mark current entries
        logic pop;      // front leaves, chain moves forward one place
        logic keep;     // popped front goes back in behind the last entry
    } olist_ctl_t;

    typedef logic signed [VAL_W-1:0] olist_val_t;

endpackage

/* rtl/core/olist_cell.sv */
module olist_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  olist_pkg::olist_ctl_t ctl,
    input  olist_pkg::olist_val_t prev_val,
    input  logic                prev_vld,
    input  olist_pkg::olist_val_t next_val,
    input  logic                next_vld,
    input  logic                next_mark,
    input  olist_pkg::olist_val_t recirc_val,
    output olist_pkg::olist_val_t val,
    output logic                vld,
    output logic                mark
);
    import olist_pkg::*;

    olist_val_t val_reg;
    olist_val_t val_next;
    logic       vld_reg;
    logic       vld_next;
    logic       mark_reg;
    logic       mark_next;
    logic       tail_here;

    // this cell is the last held entry: the popped front lands here
    assign tail_here = vld_reg && !next_vld;

    always_comb
    begin
        val_next  = val_reg;
        vld_next  = vld_reg;
        mark_next = mark_reg;
        if (ctl.ins)
        begin
            val_next  = prev_val;
            vld_next  = prev_vld;
            mark_next = prev_vld;
        end
        else if (ctl.start)
        begin
            mark_next = vld_reg;
        end
        else if (ctl.pop)
        begin
            if (ctl.keep && tail_here)
            begin
                val_next  = recirc_val;
                vld_next  = 1'b1;
                mark_next = 1'b0;
            end
            else
            begin
                val_next  = next_val;
                vld_next  = next_vld;
                mark_next = next_mark;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            mark_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            mark_reg <= mark_next;
        end
    end

    assign val  = val_reg;
    assign vld  = vld_reg;
    assign mark = mark_reg;

endmodule

/* rtl/core/ordered_list_insert_front_delete_match_core.sv */
// The last result of a word is strobed, with is_last, once every entry held when the dump
// begins (a matched delete's entry included) has passed through the front cell.
// A new word is taken only while busy is low; during a dump the chain rotates one entry
// a cycle through the front cell.
// Results cannot be stalled: each is valid for exactly one cycle with strobe.
module ordered_list_insert_front_delete_match_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  kind,
    input  olist_pkg::olist_val_t value,
    output logic                  strobe,
    output olist_pkg::olist_val_t entry_value,
    output logic                  is_last,
    output logic                  list_empty,
    output logic                  insert_rejected
);
    import olist_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic       state_reg;
    logic       state_next;
    olist_val_t key_reg;
    olist_val_t key_next;
    logic       is_del_reg;
    logic       is_del_next;
    logic       found_reg;
    logic       found_next;
    logic       rej_reg;
    logic       rej_next;
    logic       pend_vld_reg;
    logic       pend_vld_next;
    olist_val_t pend_val_reg;
    olist_val_t pend_val_next;
    logic       strobe_reg;
    logic       strobe_next;
    olist_val_t out_val_reg;
    olist_val_t out_val_next;
    logic       last_reg;
    logic       last_next;
    logic       empty_reg;
    logic       empty_next;
    logic       orej_reg;
    logic       orej_next;

    olist_ctl_t ctl;
    olist_val_t cell_val  [DEPTH];
    logic       cell_vld  [DEPTH];
    logic       cell_mark [DEPTH];
    logic [DEPTH-1:0] vld_vec;

    logic accept;
    logic full;
    logic front_pop;
    logic front_hit;

    assign accept    = start && (state_reg == ST_IDLE);
    assign full      = cell_vld[DEPTH-1];
    assign front_pop = (state_reg == ST_DUMP) && cell_vld[0] && cell_mark[0];
    assign front_hit = is_del_reg && !found_reg && (cell_val[0] == key_reg);

    always_comb
    begin
        ctl.start = accept;
        ctl.ins   = accept && (kind == KIND_INSERT) && !full;
        ctl.pop   = front_pop;
        ctl.keep  = !front_hit;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            olist_val_t pv;
            logic       pvld;
            olist_val_t nv;
            logic       nvld;
            logic       nmark;

            if (gi == 0)
            begin : g_front
                assign pv   = value;
                assign pvld = 1'b1;
            end
            else
            begin : g_mid_prev
                assign pv   = cell_val[gi-1];
                assign pvld = cell_vld[gi-1];
            end

            if (gi == DEPTH-1)
            begin : g_tail
                assign nv    = '0;
                assign nvld  = 1'b0;
                assign nmark = 1'b0;
            end
            else
            begin : g_mid_next
                assign nv    = cell_val[gi+1];
                assign nvld  = cell_vld[gi+1];
                assign nmark = cell_mark[gi+1];
            end

            olist_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .prev_val   (pv),
                .prev_vld   (pvld),
                .next_val   (nv),
                .next_vld   (nvld),
                .next_mark  (nmark),
                .recirc_val (cell_val[0]),
                .val        (cell_val[gi]),
                .vld        (cell_vld[gi]),
                .mark       (cell_mark[gi])
            );

            assign vld_vec[gi] = cell_vld[gi];
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        is_del_next   = is_del_reg;
        found_next    = found_reg;
        rej_next      = rej_reg;
        pend_vld_next = pend_vld_reg;
        pend_val_next = pend_val_reg;
        strobe_next   = 1'b0;
        out_val_next  = out_val_reg;
        last_next     = last_reg;
        empty_next    = empty_reg;
        orej_next     = orej_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next      = value;
                    is_del_next   = (kind == KIND_DELETE);
                    found_next    = 1'b0;
                    rej_next      = (kind == KIND_INSERT) && full;
                    pend_vld_next = 1'b0;
                    state_next    = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (front_pop)
                begin
                    if (front_hit)
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        // hold one survivor back so the last one can be flagged
                        if (pend_vld_reg)
                        begin
                            strobe_next  = 1'b1;
                            out_val_next = pend_val_reg;
                            last_next    = 1'b0;
                            empty_next   = 1'b0;
                            orej_next    = rej_reg;
                        end
                        pend_vld_next = 1'b1;
                        pend_val_next = cell_val[0];
                    end
                end
                else
                begin
                    strobe_next   = 1'b1;
                    out_val_next  = pend_vld_reg ? pend_val_reg : '0;
                    last_next     = 1'b1;
                    empty_next    = !pend_vld_reg;
                    orej_next     = rej_reg;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        is_del_reg   <= is_del_next;
        rej_reg      <= rej_next;
        pend_val_reg <= pend_val_next;
        out_val_reg  <= out_val_next;
        last_reg     <= last_next;
        empty_reg    <= empty_next;
        orej_reg     <= orej_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            found_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            found_reg    <= found_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign strobe          = strobe_reg;
    assign entry_value     = out_val_reg;
    assign is_last         = last_reg;
    assign list_empty      = empty_reg;
    assign insert_rejected = orej_reg;

`ifndef SYNTHESIS
    a_strobe_from_dump: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == ST_DUMP))
        else $error("result strobed without a dump in progress");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && list_empty) |-> is_last)
        else $error("empty result not flagged last");

    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec + 1'b1) & vld_vec) == '0)
        else $error("held entries do not form a run from the front");

    a_word_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start a dump");

    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && is_last) |-> !busy)
        else $error("last result strobed while still busy");
`endif

endmodule

/* dv/ordered_list_insert_front_delete_match_core_tb.sv */
module ordered_list_insert_front_delete_match_core_tb;
    import olist_pkg::*;

    localparam int PERIOD      = 10;
    localparam int RESET_LEN   = 11;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 36;

    localparam olist_val_t VAL_MIN = olist_val_t'(32'h8000_0000);
    localparam olist_val_t VAL_MAX = olist_val_t'(32'h7fff_ffff);

    typedef struct {
        logic       kind;
        olist_val_t value;
        int         gap_after;  // idle cycles before the next word
        bit         drain;      // wait for every dump to finish first
    } list_word_t;

    typedef struct {
        olist_val_t entry_value;
        logic       is_last;
        logic       list_empty;
        logic       insert_rejected;
    } dump_entry_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       kind = KIND_INSERT;
    olist_val_t value = '0;
    logic       strobe;
    olist_val_t entry_value;
    logic       is_last;
    logic       list_empty;
    logic       insert_rejected;

    list_word_t  word_queue[$];
    dump_entry_t dump_queue[$];
    olist_val_t  shadow_list[$];
    olist_val_t  value_pool[$];

    logic took = 1'b0;
    int   cur_gap = 0;
    int   gap_left = 0;
    int   idle_cycles = 0;
    int   fail_count = 0;
    int   words_taken = 0;
    int   results_seen = 0;
    int   rejected_dumps = 0;
    int   empty_dumps = 0;

    ordered_list_insert_front_delete_match_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .value           (value),
        .strobe          (strobe),
        .entry_value     (entry_value),
        .is_last         (is_last),
        .list_empty      (list_empty),
        .insert_rejected (insert_rejected)
    );

    always #(PERIOD/2) clk = ~clk;

    // apply one word to the shadow list and queue the dump it should produce
    function automatic void predict_dump(logic k, olist_val_t v);
        int          hit;
        bit          rejected;
        dump_entry_t e;
        hit = -1;
        rejected = 1'b0;
        if (k == KIND_INSERT) begin
            if (shadow_list.size() >= DEPTH)
                rejected = 1'b1;
            else
                shadow_list.push_front(v);
        end
        else begin
            foreach (shadow_list[i])
                if (hit < 0 && shadow_list[i] == v)
                    hit = i;
            if (hit >= 0)
                shadow_list.delete(hit);
        end
        if (rejected)
            rejected_dumps++;
        if (shadow_list.size() == 0) begin
            e.entry_value = '0;
            e.is_last = 1'b1;
            e.list_empty = 1'b1;
            e.insert_rejected = rejected;
            dump_queue.push_back(e);
            empty_dumps++;
        end
        else begin
            foreach (shadow_list[i]) begin
                e.entry_value = shadow_list[i];
                e.is_last = (i == shadow_list.size() - 1);
                e.list_empty = 1'b0;
                e.insert_rejected = rejected;
                dump_queue.push_back(e);
            end
        end
    endfunction

    task automatic check_field(string name, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    task automatic add_word(logic k, olist_val_t v, int gap, bit drain);
        list_word_t w;
        w.kind = k;
        w.value = v;
        w.gap_after = gap;
        w.drain = drain;
        word_queue.push_back(w);
    endtask

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(99);
        if (quiet || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 20);
        return $urandom_range(25, 60);
    endfunction

    // driver: words change at the falling edge
    always @(negedge clk) begin : driver
        list_word_t w;
        logic       drive;
        if (rst_n) begin
            drive = start;
            if (start && took) begin
                drive = 1'b0;
                gap_left = cur_gap;
            end
            if (!drive) begin
                if (gap_left > 0)
                    gap_left--;
                else if (word_queue.size() > 0 &&
                         !(word_queue[0].drain && dump_queue.size() > 0)) begin
                    w = word_queue.pop_front();
                    drive = 1'b1;
                    cur_gap = w.gap_after;
                    kind <= w.kind;
                    value <= w.value;
                end
            end
            start <= drive;
        end
    end

    // monitor: results and accepted words sampled at the rising edge
    always @(posedge clk) begin : monitor
        dump_entry_t want;
        logic        accepted;
        if (rst_n) begin
            accepted = start && !busy;
            if (strobe) begin
                results_seen++;
                if (dump_queue.size() == 0) begin
                    $error("unexpected result: entry_value %0d", entry_value);
                    fail_count++;
                end
                else begin
                    want = dump_queue.pop_front();
                    check_field("entry_value", entry_value, want.entry_value);
                    check_field("is_last", is_last, want.is_last);
                    check_field("list_empty", list_empty, want.list_empty);
                    check_field("insert_rejected", insert_rejected, want.insert_rejected);
                end
            end
            if (accepted) begin
                predict_dump(kind, value);
                words_taken++;
            end
            took <= accepted;
            if (strobe || accepted)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int         insert_pct[PHASES];
        olist_val_t v;
        bit         quiet;

        insert_pct = '{90, 20, 60, 95, 10, 55, 50};

        // directed: empty list, extremes, duplicates, full list
        add_word(KIND_DELETE, 5, 0, 1'b0);
        add_word(KIND_INSERT, VAL_MIN, 0, 1'b0);
        add_word(KIND_INSERT, VAL_MAX, 3, 1'b0);
        add_word(KIND_INSERT, 0, 0, 1'b0);
        add_word(KIND_INSERT, -1, 7, 1'b0);
        add_word(KIND_INSERT, 7, 0, 1'b0);
        add_word(KIND_INSERT, 7, 0, 1'b0);
        add_word(KIND_DELETE, 7, 1, 1'b0);      // frontmost of two
        add_word(KIND_DELETE, 12345, 0, 1'b0);  // no match
        add_word(KIND_DELETE, VAL_MIN, 0, 1'b0); // tail entry
        for (int i = 0; i < 12; i++)
            add_word(KIND_INSERT, 100 + i, 0, 1'b0);
        add_word(KIND_INSERT, 999, 0, 1'b0);    // full list
        add_word(KIND_DELETE, 111, 2, 1'b0);    // front entry
        add_word(KIND_DELETE, -1, 0, 1'b0);     // middle entry

        // random phases with a small value pool so deletes usually match
        for (int p = 0; p < PHASES; p++) begin
            value_pool.delete();
            value_pool.push_back(0);
            value_pool.push_back(-1);
            value_pool.push_back(VAL_MIN);
            value_pool.push_back(VAL_MAX);
            for (int j = 0; j < 6; j++)
                value_pool.push_back(olist_val_t'($urandom));
            quiet = (p == 3 || p == 5);
            for (int j = 0; j < PHASE_WORDS; j++) begin
                if ($urandom_range(99) < 75)
                    v = value_pool[$urandom_range(value_pool.size() - 1)];
                else
                    v = olist_val_t'($urandom);
                add_word(($urandom_range(99) < insert_pct[p]) ? KIND_INSERT : KIND_DELETE,
                         v, pick_gap(quiet), j == 0);
            end
        end

        repeat (RESET_LEN) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (word_queue.size() != 0 || start || dump_queue.size() != 0);
        repeat (DEPTH + 4) @(posedge clk);

        $display("%0d words driven, %0d entries checked", words_taken, results_seen);
        $display("%0d dumps after a rejected insert, %0d empty-list dumps",
                 rejected_dumps, empty_dumps);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
